// ===== sv/spc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the smoothed cursor block
// Field widths, register indexes, reset values and the request structs.
// ----------------------------------------------------------------------------
package spc_pkg;

	localparam int COORD_BITS       = 12;
	localparam int ZONE_BITS        = COORD_BITS;
	localparam int SCREEN_BITS      = 13;
	localparam int WS_BITS          = 4;
	localparam int REG_IDX_BITS     = 3;
	localparam int CFG_DATA_BITS    = 13;
	localparam int DEF_WINDOW_DEPTH = 8;

	localparam logic [WS_BITS-1:0]     RST_WINDOW_SIZE   = WS_BITS'(8);
	localparam logic [ZONE_BITS-1:0]   RST_ZONE_MIN_X    = ZONE_BITS'(0);
	localparam logic [ZONE_BITS-1:0]   RST_ZONE_MAX_X    = ZONE_BITS'(639);
	localparam logic [ZONE_BITS-1:0]   RST_ZONE_MIN_Y    = ZONE_BITS'(0);
	localparam logic [ZONE_BITS-1:0]   RST_ZONE_MAX_Y    = ZONE_BITS'(479);
	localparam logic [SCREEN_BITS-1:0] RST_SCREEN_WIDTH  = SCREEN_BITS'(1920);
	localparam logic [SCREEN_BITS-1:0] RST_SCREEN_HEIGHT = SCREEN_BITS'(1080);

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_WINDOW_SIZE   = 3'd0,
		REG_ZONE_MIN_X    = 3'd1,
		REG_ZONE_MAX_X    = 3'd2,
		REG_ZONE_MIN_Y    = 3'd3,
		REG_ZONE_MAX_Y    = 3'd4,
		REG_SCREEN_WIDTH  = 3'd5,
		REG_SCREEN_HEIGHT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
	} pos_t;

	typedef struct packed {
		logic [SCREEN_BITS-1:0] cursor_x;
		logic [SCREEN_BITS-1:0] cursor_y;
	} cursor_t;

	// Per-request control handed from the top level to both axis units.
	typedef struct packed {
		logic               start;
		logic               clear;
		logic               full;
		logic [WS_BITS-1:0] fill;
	} cmd_t;

	function automatic int slot_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

// ===== sv/smoothed_position_to_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smoothed_position_to_cursor: moving-average smoothing with a range map
// Averages the last window_size points per axis and maps them onto the screen.
// ----------------------------------------------------------------------------
// Each request on pos carries one tracked point. Both axes keep a ring of the
// last N samples (N = window_size, with zero read as one and values above
// WINDOW_DEPTH read as WINDOW_DEPTH) and a running sum; while the ring fills
// the sum is divided by the number of samples held. The truncated average is
// mapped as (avg - zone_min) * screen_extent / (zone_max - zone_min), the
// quotient truncated toward zero, clamped to 0..screen_extent, and forced to
// zero when the zone is empty. Exactly one cursor request comes out per
// point. The two axes run side by side, each in its own bit-serial unit: a
// point passes through the sum update, 16 average quotient bits at the
// default depth, the map setup, 13 shift-add multiply steps, 25 range
// quotient bits and the clamp before it is loaded into the output register.
// The block takes no new point while one is in the serial datapath; a new
// point is taken as soon as the result has moved into the output register,
// even while that result still waits for cursor_ready. Writing window_size
// empties the rings; configuration must be written only while idle, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
module smoothed_position_to_cursor
	import spc_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     pos_valid,
	output logic                     pos_ready,
	input  pos_t                     pos,
	output logic                     cursor_valid,
	input  logic                     cursor_ready,
	output cursor_t                  cursor,
	input  logic                     cfg_wr_en,
	input  logic [REG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int SLOT_BITS = slot_bits(WINDOW_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t                  state_q;
	logic [WS_BITS-1:0]      ws_q;
	logic [ZONE_BITS-1:0]    zmin_x_q;
	logic [ZONE_BITS-1:0]    zmax_x_q;
	logic [ZONE_BITS-1:0]    zmin_y_q;
	logic [ZONE_BITS-1:0]    zmax_y_q;
	logic [SCREEN_BITS-1:0]  scr_w_q;
	logic [SCREEN_BITS-1:0]  scr_h_q;
	logic [WS_BITS-1:0]      fill_q;
	logic [SLOT_BITS-1:0]    slot_q;
	logic                    cursor_valid_q;
	cursor_t                 cursor_q;

	logic [WS_BITS-1:0]      n_w;
	logic [WS_BITS-1:0]      fill_eff;
	logic [SLOT_BITS-1:0]    slot_eff;
	logic [SLOT_BITS-1:0]    slot_new;
	logic [WS_BITS-1:0]      fill_new;
	cmd_t                    cmd;
	logic [SCREEN_BITS-1:0]  x_res;
	logic [SCREEN_BITS-1:0]  y_res;
	logic                    x_done;
	logic                    y_done;
	logic                    load;

	// Effective window length and ring bookkeeping for the next point.
	always_comb begin
		if (ws_q == '0) begin
			n_w = WS_BITS'(1);
		end else if (int'(ws_q) > WINDOW_DEPTH) begin
			n_w = WS_BITS'(WINDOW_DEPTH);
		end else begin
			n_w = ws_q;
		end
		fill_eff = (fill_q > n_w) ? n_w : fill_q;
		slot_eff = (int'(slot_q) >= int'(n_w)) ? '0 : slot_q;
		slot_new = (int'(slot_eff) + 1 >= int'(n_w)) ? '0 : slot_eff + 1'b1;
		fill_new = (fill_eff == n_w) ? fill_eff : fill_eff + 1'b1;

		cmd.start = pos_valid && pos_ready;
		cmd.clear = cfg_wr_en && (cfg_index == REG_WINDOW_SIZE);
		cmd.full  = (fill_eff == n_w);
		cmd.fill  = fill_new;
	end

	assign pos_ready = (state_q == ST_IDLE);

	// Configuration registers and ring position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q     <= RST_WINDOW_SIZE;
			zmin_x_q <= RST_ZONE_MIN_X;
			zmax_x_q <= RST_ZONE_MAX_X;
			zmin_y_q <= RST_ZONE_MIN_Y;
			zmax_y_q <= RST_ZONE_MAX_Y;
			scr_w_q  <= RST_SCREEN_WIDTH;
			scr_h_q  <= RST_SCREEN_HEIGHT;
			fill_q   <= '0;
			slot_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_WINDOW_SIZE:   ws_q     <= cfg_data[WS_BITS-1:0];
					REG_ZONE_MIN_X:    zmin_x_q <= cfg_data[ZONE_BITS-1:0];
					REG_ZONE_MAX_X:    zmax_x_q <= cfg_data[ZONE_BITS-1:0];
					REG_ZONE_MIN_Y:    zmin_y_q <= cfg_data[ZONE_BITS-1:0];
					REG_ZONE_MAX_Y:    zmax_y_q <= cfg_data[ZONE_BITS-1:0];
					REG_SCREEN_WIDTH:  scr_w_q  <= cfg_data[SCREEN_BITS-1:0];
					REG_SCREEN_HEIGHT: scr_h_q  <= cfg_data[SCREEN_BITS-1:0];
					default: begin
						// drop writes to unknown indexes
					end
				endcase
			end
			if (cmd.clear) begin
				fill_q <= '0;
				slot_q <= '0;
			end else if (cmd.start) begin
				fill_q <= fill_new;
				slot_q <= slot_new;
			end
		end
	end

	spc_axis #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.slot     (slot_eff),
		.pos      (pos.pos_x),
		.zone_min (zmin_x_q),
		.zone_max (zmax_x_q),
		.out_max  (scr_w_q),
		.result   (x_res),
		.done     (x_done)
	);

	spc_axis #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_axis_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.slot     (slot_eff),
		.pos      (pos.pos_y),
		.zone_min (zmin_y_q),
		.zone_max (zmax_y_q),
		.out_max  (scr_h_q),
		.result   (y_res),
		.done     (y_done)
	);

	// Move the finished point into the output register once it is free;
	// hold it in the axis units while an earlier result still waits.
	assign load = ((state_q == ST_RUN) && x_done && (!cursor_valid_q || cursor_ready))
		|| ((state_q == ST_HOLD) && cursor_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cursor_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (x_done) begin
						state_q <= load ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (cursor_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				cursor_valid_q <= 1'b1;
			end else if (cursor_ready) begin
				cursor_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cursor_q.cursor_x <= x_res;
			cursor_q.cursor_y <= y_res;
		end
	end

	assign cursor_valid = cursor_valid_q;
	assign cursor       = cursor_q;

	a_ring_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= n_w) && (int'(slot_q) < int'(n_w)))
		else $error("ring position or fill count beyond window");

	a_axes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		x_done == y_done)
		else $error("axis units out of step");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		x_done |-> (state_q == ST_RUN))
		else $error("axis result arrived outside a running point");

	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && pos_ready) |=> !pos_ready)
		else $error("second point taken while one is in flight");

endmodule

// ===== sv/spc_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_axis: one coordinate of the smoothed cursor map
// Sample ring, running sum, bit-serial average divide, serial multiply by
// the screen extent and bit-serial range divide, then clamp.
// ----------------------------------------------------------------------------
module spc_axis
	import spc_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cmd_t                               cmd,
	input  logic [slot_bits(WINDOW_DEPTH)-1:0] slot,
	input  logic [COORD_BITS-1:0]              pos,
	input  logic [ZONE_BITS-1:0]               zone_min,
	input  logic [ZONE_BITS-1:0]               zone_max,
	input  logic [SCREEN_BITS-1:0]             out_max,
	output logic [SCREEN_BITS-1:0]             result,
	output logic                               done
);

	localparam int WS_MAX    = (1 << WS_BITS) - 1;
	localparam int NMAX      = (WINDOW_DEPTH < WS_MAX) ? WINDOW_DEPTH : WS_MAX;
	localparam int SUM_BITS  = COORD_BITS + $clog2(NMAX + 1);
	localparam int DIFF_BITS = COORD_BITS + 1;
	localparam int PROD_BITS = COORD_BITS + SCREEN_BITS;
	localparam int DVD_BITS  = (PROD_BITS > SUM_BITS) ? PROD_BITS : SUM_BITS;
	localparam int DIVR_BITS = COORD_BITS;
	localparam int CNT_BITS  = $clog2(DVD_BITS);

	typedef enum logic [6:0] {
		A_IDLE = 7'b0000001,
		A_SUM  = 7'b0000010,
		A_AVG  = 7'b0000100,
		A_PREP = 7'b0001000,
		A_MUL  = 7'b0010000,
		A_DIV  = 7'b0100000,
		A_FIN  = 7'b1000000
	} ax_state_t;

	ax_state_t               state_q;
	logic [COORD_BITS-1:0]   hist_mem [WINDOW_DEPTH];
	logic [COORD_BITS-1:0]   old_q;
	logic [COORD_BITS-1:0]   pos_q;
	logic                    full_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic [DVD_BITS-1:0]     dvd_q;
	logic [DIVR_BITS-1:0]    rem_q;
	logic [DIVR_BITS-1:0]    divr_q;
	logic [CNT_BITS-1:0]     cnt_q;
	logic [COORD_BITS-1:0]   mcand_q;
	logic [PROD_BITS-1:0]    prod_q;
	logic                    neg_q;
	logic                    zero_q;
	logic [SCREEN_BITS-1:0]  result_q;
	logic                    done_q;

	logic [SUM_BITS-1:0]     sum_nxt;
	logic [DIVR_BITS:0]      rem_sh;
	logic [DIVR_BITS+1:0]    trial;
	logic                    take;
	logic [DIVR_BITS-1:0]    rem_nxt;
	logic [DVD_BITS-1:0]     dvd_nxt;
	logic [COORD_BITS-1:0]   avg;
	logic [DIFF_BITS-1:0]    diff;
	logic [DIFF_BITS-1:0]    den;
	logic [DIFF_BITS-1:0]    diff_abs;
	logic [DIFF_BITS-1:0]    den_abs;
	logic [COORD_BITS:0]     padd;
	logic [PROD_BITS-1:0]    prod_nxt;
	logic [PROD_BITS-1:0]    quo;

	// Ring of samples; the read returns the entry being replaced.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			old_q          <= hist_mem[slot];
			hist_mem[slot] <= pos;
		end
	end

	always_comb begin
		sum_nxt  = sum_q - (full_q ? SUM_BITS'(old_q) : '0) + SUM_BITS'(pos_q);

		// one restoring-division step
		rem_sh   = {rem_q, dvd_q[DVD_BITS-1]};
		trial    = {1'b0, rem_sh} - {2'b00, divr_q};
		take     = !trial[DIVR_BITS+1];
		rem_nxt  = take ? trial[DIVR_BITS-1:0] : rem_sh[DIVR_BITS-1:0];
		dvd_nxt  = {dvd_q[DVD_BITS-2:0], take};

		avg      = dvd_q[COORD_BITS-1:0];
		diff     = {1'b0, avg} - {1'b0, zone_min};
		den      = {1'b0, zone_max} - {1'b0, zone_min};
		diff_abs = diff[DIFF_BITS-1] ? -diff : diff;
		den_abs  = den[DIFF_BITS-1] ? -den : den;

		// one shift-add multiply step
		padd     = {1'b0, prod_q[PROD_BITS-1:SCREEN_BITS]}
			+ (prod_q[0] ? {1'b0, mcand_q} : '0);
		prod_nxt = {padd, prod_q[SCREEN_BITS-1:1]};

		quo      = dvd_q[PROD_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			sum_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (cmd.start) begin
						state_q <= A_SUM;
					end
				end
				A_SUM: begin
					sum_q   <= sum_nxt;
					state_q <= A_AVG;
				end
				A_AVG: begin
					if (cnt_q == '0) begin
						state_q <= A_PREP;
					end
				end
				A_PREP: begin
					state_q <= A_MUL;
				end
				A_MUL: begin
					if (cnt_q == '0) begin
						state_q <= A_DIV;
					end
				end
				A_DIV: begin
					if (cnt_q == '0) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					done_q  <= 1'b1;
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
			if (cmd.clear) begin
				sum_q <= '0;
			end
		end
	end

	// Datapath registers; sequenced by the state above.
	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (cmd.start) begin
					pos_q  <= pos;
					full_q <= cmd.full;
					divr_q <= DIVR_BITS'(cmd.fill);
				end
			end
			A_SUM: begin
				dvd_q <= DVD_BITS'(sum_nxt) << (DVD_BITS - SUM_BITS);
				rem_q <= '0;
				cnt_q <= CNT_BITS'(SUM_BITS - 1);
			end
			A_AVG, A_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q - 1'b1;
			end
			A_PREP: begin
				neg_q   <= diff[DIFF_BITS-1] ^ den[DIFF_BITS-1];
				zero_q  <= (den == '0);
				mcand_q <= diff_abs[COORD_BITS-1:0];
				divr_q  <= den_abs[DIVR_BITS-1:0];
				prod_q  <= {{COORD_BITS{1'b0}}, out_max};
				cnt_q   <= CNT_BITS'(SCREEN_BITS - 1);
			end
			A_MUL: begin
				prod_q <= prod_nxt;
				if (cnt_q == '0) begin
					dvd_q <= DVD_BITS'(prod_nxt) << (DVD_BITS - PROD_BITS);
					rem_q <= '0;
					cnt_q <= CNT_BITS'(PROD_BITS - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			A_FIN: begin
				// negative quotients and an empty zone clamp to zero
				if (zero_q || neg_q) begin
					result_q <= '0;
				end else if (quo > PROD_BITS'(out_max)) begin
					result_q <= out_max;
				end else begin
					result_q <= quo[SCREEN_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// ===== tb/sv/tb_smoothed_position_to_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_position_to_cursor: self-checking regression of the cursor map
// Sends tracked points, predicts each smoothed and mapped cursor request from
// a local model of the rings, sums and register file, and compares every
// returned request field by field under changing settings and traffic.
// ----------------------------------------------------------------------------
module tb_smoothed_position_to_cursor;
	import spc_pkg::*;

	localparam int WINDOW_DEPTH = DEF_WINDOW_DEPTH;
	// Index with no register behind it; writes to it must be dropped.
	localparam logic [REG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int PLAN_ROWS    = 41;
	localparam int PHASE_COUNT  = 12;
	localparam int PHASE_POINTS = 82;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 100;
	localparam int MAX_REPORTS  = 10;
	localparam int TIMEOUT_NS   = 10_000_000;

	typedef enum bit {ROW_CFG, ROW_POINT} row_kind_t;

	// One directed step: a register write, or a point with an optional
	// hand-computed cursor (known = 1) that replaces the predicted one.
	typedef struct {
		row_kind_t               kind;
		logic [REG_IDX_BITS-1:0] idx;
		int                      val;
		int                      px;
		int                      py;
		bit                      known;
		int                      wx;
		int                      wy;
	} plan_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     pos_valid;
	logic                     pos_ready;
	pos_t                     pos;
	logic                     cursor_valid;
	logic                     cursor_ready;
	cursor_t                  cursor;
	logic                     cfg_wr_en;
	logic [REG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// Local copy of the register file and of the smoothing state.
	int win_reg;
	int zmin_x;
	int zmax_x;
	int zmin_y;
	int zmax_y;
	int span_x;
	int span_y;
	int hist_x [WINDOW_DEPTH];
	int hist_y [WINDOW_DEPTH];
	int acc_x;
	int acc_y;
	int held;
	int next_slot;

	cursor_t cursor_due [$];
	int      mismatch_count;
	int      send_idle_pct;
	int      recv_stall_pct;
	bit      hold_req;

	// Directed steps; the register index of a point row is not used.
	plan_row_t plan [PLAN_ROWS] = '{
		// reset settings: window 8, x zone 0..639 onto 0..1920, y 0..479 onto 0..1080
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 0, 1, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 4095, 4095, 1, 1920, 1080},
		'{ROW_CFG, REG_WINDOW_SIZE, 1, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 639, 479, 1, 1920, 1080},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 320, 240, 0, 0, 0},
		// a window of zero behaves as a window of one
		'{ROW_CFG, REG_WINDOW_SIZE, 0, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 100, 50, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 0, 1, 0, 0},
		// all data bits set: masks to 15, behaves as the full depth
		'{ROW_CFG, REG_WINDOW_SIZE, 8191, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 4095, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 4095, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 1234, 567, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 2730, 1365, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 1365, 2730, 0, 0, 0},
		'{ROW_CFG, REG_WINDOW_SIZE, 9, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 600, 400, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 10, 20, 0, 0, 0},
		'{ROW_CFG, REG_UNUSED, 5461, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 300, 300, 0, 0, 0},
		// empty x zone, reversed y zone (min written wide, masks to 4095)
		'{ROW_CFG, REG_WINDOW_SIZE, 1, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MIN_X, 100, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MAX_X, 100, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MIN_Y, 8191, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MAX_Y, 0, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 4095, 0, 1, 0, 1080},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 4095, 1, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 100, 2048, 0, 0, 0},
		// full zones, widest and narrowest screens
		'{ROW_CFG, REG_ZONE_MIN_X, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MAX_X, 8191, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MIN_Y, 0, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MAX_Y, 4095, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SCREEN_WIDTH, 8191, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_SCREEN_HEIGHT, 0, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 4095, 4095, 1, 8191, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 0, 1, 0, 0},
		'{ROW_CFG, REG_SCREEN_HEIGHT, 8191, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 2047, 4095, 0, 0, 0},
		// point below the zone: negative quotient clamps to zero
		'{ROW_CFG, REG_ZONE_MIN_X, 1000, 0, 0, 0, 0, 0},
		'{ROW_CFG, REG_ZONE_MAX_X, 3000, 0, 0, 0, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 0, 0, 1, 0, 0},
		'{ROW_POINT, REG_WINDOW_SIZE, 0, 1999, 4095, 0, 0, 0}
	};

	smoothed_position_to_cursor i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pos_valid    (pos_valid),
		.pos_ready    (pos_ready),
		.pos          (pos),
		.cursor_valid (cursor_valid),
		.cursor_ready (cursor_ready),
		.cursor       (cursor),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop all held samples; the ring contents stay but are never read again
	// before being overwritten.
	function automatic void empty_window();
		acc_x = 0;
		acc_y = 0;
		held = 0;
		next_slot = 0;
	endfunction

	// Mirror one register write, masked to the register's width.
	function automatic void load_reg(input logic [REG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
		REG_WINDOW_SIZE: begin
			win_reg = int'(val[WS_BITS-1:0]);
			empty_window();
		end
		REG_ZONE_MIN_X:    zmin_x = int'(val[ZONE_BITS-1:0]);
		REG_ZONE_MAX_X:    zmax_x = int'(val[ZONE_BITS-1:0]);
		REG_ZONE_MIN_Y:    zmin_y = int'(val[ZONE_BITS-1:0]);
		REG_ZONE_MAX_Y:    zmax_y = int'(val[ZONE_BITS-1:0]);
		REG_SCREEN_WIDTH:  span_x = int'(val[SCREEN_BITS-1:0]);
		REG_SCREEN_HEIGHT: span_y = int'(val[SCREEN_BITS-1:0]);
		default: ;
		endcase
	endfunction

	// Linear zone map; int division truncates toward zero like the block.
	function automatic logic [SCREEN_BITS-1:0] zone_map(input int avg, input int zlo,
			input int zhi, input int span);
		int q;
		if (zhi == zlo)
			return '0;
		q = (avg - zlo) * span / (zhi - zlo);
		if (q < 0)
			q = 0;
		if (q > span)
			q = span;
		return SCREEN_BITS'(q);
	endfunction

	// Push one point into the rings and return the cursor it produces.
	function automatic cursor_t smooth_and_map(input pos_t pt);
		int n;
		int slot;
		cursor_t res;
		n = (win_reg == 0) ? 1 : (win_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : win_reg;
		if (next_slot >= n)
			next_slot = 0;
		if (held > n)
			held = n;
		slot = next_slot;
		// full ring: retire the oldest sample from the sums
		if (held == n) begin
			acc_x -= hist_x[slot];
			acc_y -= hist_y[slot];
		end else begin
			held++;
		end
		hist_x[slot] = int'(pt.pos_x);
		hist_y[slot] = int'(pt.pos_y);
		acc_x += hist_x[slot];
		acc_y += hist_y[slot];
		next_slot = (slot + 1 >= n) ? 0 : slot + 1;
		res.cursor_x = zone_map(acc_x / held, zmin_x, zmax_x, span_x);
		res.cursor_y = zone_map(acc_y / held, zmin_y, zmax_y, span_y);
		return res;
	endfunction

	// Write one register, then drop the enable before the next write so back-to-back
	// writes never assign the enable twice in one step.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_BITS'(val);
		@(posedge clk);
		load_reg(idx, CFG_DATA_BITS'(val));
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering points and wait until every cursor request is back.
	task automatic settle_points();
		pos_valid <= 1'b0;
		@(posedge clk);
		while (cursor_due.size() != 0)
			@(posedge clk);
	endtask

	// Offer one point, hold it until accepted, then queue its cursor.
	task automatic send_point(input pos_t pt, input bit known, input cursor_t given);
		cursor_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			pos_valid <= 1'b0;
			@(posedge clk);
		end
		pos_valid <= 1'b1;
		pos <= pt;
		@(posedge clk);
		while (!pos_ready)
			@(posedge clk);
		predicted = smooth_and_map(pt);
		if (known)
			predicted = given;
		cursor_due = {cursor_due, predicted};
	endtask

	// Mostly land inside the zone so the map is not just clamping; the rest
	// is any 12-bit value.
	function automatic logic [COORD_BITS-1:0] pick_coord(input int zlo, input int zhi);
		int lo;
		int hi;
		if ($urandom_range(9) < 3)
			return COORD_BITS'($urandom);
		lo = (zlo < zhi) ? zlo : zhi;
		hi = (zlo < zhi) ? zhi : zlo;
		return COORD_BITS'($urandom_range(hi, lo));
	endfunction

	// Choose new settings for a phase. Even phases rewrite the window and
	// so restart smoothing; odd ones keep the history across zone changes.
	task automatic pick_settings(input int phase);
		int ws;
		int a;
		int b;
		int t;
		int s;
		int kind;
		if (phase % 2 == 0) begin
			ws = ($urandom_range(9) < 7) ? $urandom_range(8, 1) : $urandom_range(15);
			write_reg(REG_WINDOW_SIZE, ws | (int'($urandom_range(511)) << 4));
		end
		for (int axis = 0; axis < 2; axis++) begin
			kind = (phase == 1) ? 2 : $urandom_range(9);
			a = $urandom_range(4095);
			b = $urandom_range(4095);
			case (kind)
			0: b = a;
			1: if (a < b) begin
				t = a;
				a = b;
				b = t;
			end
			2: begin
				a = 0;
				b = 4095;
			end
			default: if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			endcase
			// set the unused top data bit now and then; it must be masked off
			write_reg(axis ? REG_ZONE_MIN_Y : REG_ZONE_MIN_X,
				a | (int'($urandom_range(1)) << 12));
			write_reg(axis ? REG_ZONE_MAX_Y : REG_ZONE_MAX_X,
				b | (int'($urandom_range(1)) << 12));
			kind = $urandom_range(9);
			if (phase == 1 || kind == 1)
				s = 8191;
			else if (phase == 2 || kind == 0)
				s = 0;
			else
				s = $urandom_range(8191, 1);
			write_reg(axis ? REG_SCREEN_HEIGHT : REG_SCREEN_WIDTH, s);
		end
	endtask

	// Main sequence: reset, directed table, then randomized phases.
	initial begin
		pos_t pt;
		cursor_t given;
		arst_n = 1'b0;
		pos_valid = 1'b0;
		pos = '0;
		cursor_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		win_reg = int'(RST_WINDOW_SIZE);
		zmin_x = int'(RST_ZONE_MIN_X);
		zmax_x = int'(RST_ZONE_MAX_X);
		zmin_y = int'(RST_ZONE_MIN_Y);
		zmax_y = int'(RST_ZONE_MAX_Y);
		span_x = int'(RST_SCREEN_WIDTH);
		span_y = int'(RST_SCREEN_HEIGHT);
		empty_window();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; registers change only once all requests are back.
		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_CFG) begin
				settle_points();
				write_reg(plan[r].idx, plan[r].val);
			end else begin
				pt.pos_x = COORD_BITS'(plan[r].px);
				pt.pos_y = COORD_BITS'(plan[r].py);
				given.cursor_x = SCREEN_BITS'(plan[r].wx);
				given.cursor_y = SCREEN_BITS'(plan[r].wy);
				send_point(pt, plan[r].known, given);
			end
		end

		// Random phases, cycling through the idle and stall mixes.
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			settle_points();
			pick_settings(ph);
			send_idle_pct = (ph % 4 == 1) ? 51 : (ph % 4 == 3) ? 31 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 51 : (ph % 4 == 3) ? 31 : 0;
			// long receiver hold while points keep coming: fills the block
			if (ph == 4)
				hold_req = 1'b1;
			for (int k = 0; k < PHASE_POINTS; k++) begin
				// pause the sender until the block has emptied out
				if (ph == 6 && k == PHASE_POINTS / 2)
					settle_points();
				pt.pos_x = pick_coord(zmin_x, zmax_x);
				pt.pos_y = pick_coord(zmin_y, zmax_y);
				send_point(pt, 1'b0, '0);
			end
		end

		settle_points();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cursor_due.size() == 0) begin
			$display("smoothed_position_to_cursor regression: pass");
		end else begin
			$display("smoothed_position_to_cursor regression: fail");
		end
		$finish;
	end

	// Receiver: random stalls at the phase's rate, or a counted long hold.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				cursor_ready <= 1'b0;
			end else begin
				cursor_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check each accepted cursor request against the oldest one due.
	always @(posedge clk) begin
		cursor_t want;
		if (arst_n && cursor_valid && cursor_ready) begin
			if (cursor_due.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: cursor request with none due: x=%0d y=%0d",
						$time, cursor.cursor_x, cursor.cursor_y);
				mismatch_count++;
			end else begin
				want = cursor_due[0];
				cursor_due.delete(0);
				if (cursor.cursor_x !== want.cursor_x ||
						cursor.cursor_y !== want.cursor_y) begin
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: cursor mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
							$time, want.cursor_x, want.cursor_y,
							cursor.cursor_x, cursor.cursor_y);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("smoothed_position_to_cursor regression: fail");
		$finish;
	end

endmodule
